>>> hdl/column_projection_char_cutter_top_defines.svh
// ----------------------------------------------------------------------------
// Column projection character cutter: assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COLUMN_PROJECTION_CHAR_CUTTER_TOP_DEFINES_SVH
`define COLUMN_PROJECTION_CHAR_CUTTER_TOP_DEFINES_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset
`define CCUT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ccut assertion failed");
// Antecedent in one cycle implies consequent in the next
`define CCUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccut assertion failed");
`else
`define CCUT_ASSERT(lbl, clk, rst_n, prop)
`define CCUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/ccut_pkg.sv
// ----------------------------------------------------------------------------
// ccut_pkg
// Shared types, constants and constant-divide helpers of the character cutter.
// ----------------------------------------------------------------------------
`default_nettype none

package ccut_pkg;

    // Sizing limits
    localparam int MAX_COLS = 512;
    localparam int MAX_ROWS = 256;

    localparam logic [9:0] COLS_CAP =
        (MAX_COLS > 1023) ? 10'd1023 : 10'(MAX_COLS);
    localparam logic [7:0] ROW_LAST_RESET =
        (MAX_ROWS - 1 > 255) ? 8'd255 : 8'(MAX_ROWS - 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_COLS = 2'd0;
    localparam logic [1:0] CFG_ROW_FIRST  = 2'd1;
    localparam logic [1:0] CFG_ROW_LAST   = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd3;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SPARSE = 2'd1,
        ST_WIDE   = 2'd2
    } t_status;

    // Configuration register set
    typedef struct packed {
        logic [9:0]  image_cols;
        logic [7:0]  row_first;
        logic [7:0]  row_last;
        logic [15:0] threshold;
    } t_cfg;

    // Finished run, handed from the scanner to the judge
    typedef struct packed {
        logic [24:0] run_acc;
        logic [9:0]  left;
        logic [9:0]  right;
    } t_snap;

    // x / 10 for x < 1024: reciprocal multiply, exact in this range
    function automatic logic [6:0] div10(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:11];
    endfunction

    // x / 8
    function automatic logic [6:0] div8(input logic [9:0] x);
        return x[9:3];
    endfunction

    // x / 12 = (x / 4) / 3, the divide by three exact for values below 512
    function automatic logic [6:0] div12(input logic [9:0] x);
        logic [16:0] p;
        p = 17'(x[9:2]) * 17'd171;
        return p[15:9];
    endfunction

    // x / 7 for x < 1024: reciprocal multiply, exact in this range
    function automatic logic [7:0] div7(input logic [9:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'd2341;
        return p[21:14];
    endfunction

endpackage

`default_nettype wire

>>> hdl/ccut_scan.sv
// ----------------------------------------------------------------------------
// ccut_scan
// Per-pixel column summing and run search; hands a run snapshot on image end.
// ----------------------------------------------------------------------------
`default_nettype none

module ccut_scan (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ccut_pkg::t_cfg  i_cfg,
    // cut count as seen by this cycle's pixel, including a run graded now
    input  wire logic [1:0]      i_cut_cnt,
    // pixel channel
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_pixel,
    input  wire logic [7:0]      i_row,
    input  wire logic [8:0]      i_column,
    input  wire logic            i_column_end,
    input  wire logic            i_image_end,
    input  wire logic [8:0]      i_start_column,
    // snapshot to the judge
    output logic                 o_snap_valid,
    input  wire logic            i_snap_ready,
    output ccut_pkg::t_snap      o_snap
);
    import ccut_pkg::*;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_SEARCH,
        PH_RUN,
        PH_DONE
    } t_phase;

    t_phase       r_phase,     n_phase;
    logic [15:0]  r_col_acc,   n_col_acc;
    logic [24:0]  r_run_acc,   n_run_acc;
    logic [9:0]   r_left,      n_left;
    logic [9:0]   r_right,     n_right;
    logic [8:0]   r_origin,    n_origin;
    logic         r_snap_valid, n_snap_valid;
    t_snap        r_snap,      n_snap;

    logic         accept;
    logic         in_window;
    logic [16:0]  col_add;
    logic [15:0]  col_sum;
    logic [25:0]  run_add;
    logic [10:0]  width;
    logic [6:0]   min_width;

    // Stall only while a finished run cannot move on
    assign o_in_ready = !r_snap_valid || i_snap_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Minimum run width depends on how many good cuts came before
    always_comb begin
        case (i_cut_cnt)
            2'd0:    min_width = div10(i_cfg.image_cols);
            2'd2:    min_width = div8(i_cfg.image_cols);
            default: min_width = div12(i_cfg.image_cols);
        endcase
    end

    // Saturating column sum including this pixel
    assign in_window = (i_row >= i_cfg.row_first) && (i_row <= i_cfg.row_last);
    assign col_add   = {1'b0, r_col_acc} + 17'(i_pixel);
    always_comb begin
        if (!in_window) begin
            col_sum = r_col_acc;
        end else if (col_add[16]) begin
            col_sum = '1;
        end else begin
            col_sum = col_add[15:0];
        end
    end

    assign run_add = {1'b0, r_run_acc} + 26'(col_sum);
    assign width   = {2'b00, i_column} - {1'b0, r_left};

    // Next state for one accepted pixel
    always_comb begin
        n_phase      = r_phase;
        n_col_acc    = r_col_acc;
        n_run_acc    = r_run_acc;
        n_left       = r_left;
        n_right      = r_right;
        n_origin     = r_origin;
        n_snap       = r_snap;
        n_snap_valid = r_snap_valid && !i_snap_ready;

        if (accept) begin
            // first pixel of an image opens a new search
            if (r_phase == PH_WAIT) begin
                n_origin  = i_start_column;
                n_left    = {1'b0, i_start_column};
                n_right   = '0;
                n_run_acc = '0;
                n_phase   = PH_SEARCH;
            end

            n_col_acc = col_sum;

            // column close: columns past the image width are dropped
            if (i_column_end || i_image_end) begin
                if ({1'b0, i_column} < i_cfg.image_cols) begin
                    if (r_phase == PH_SEARCH || r_phase == PH_WAIT) begin
                        if (i_column >= n_origin && col_sum > i_cfg.threshold) begin
                            n_left    = {1'b0, i_column};
                            n_right   = {1'b0, i_column};
                            n_run_acc = 25'(col_sum);
                            n_phase   = PH_RUN;
                        end
                    end else if (r_phase == PH_RUN) begin
                        n_run_acc = run_add[25] ? '1 : run_add[24:0];
                        if (col_sum < i_cfg.threshold) begin
                            n_right = {1'b0, i_column};
                            if ($signed(width) >= $signed({4'b0000, min_width})) begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                end
                n_col_acc = '0;
            end

            // image end: close the run and hand it over
            if (i_image_end) begin
                if (n_phase != PH_DONE) begin
                    n_right = i_cfg.image_cols;
                end
                n_snap.run_acc = n_run_acc;
                n_snap.left    = n_left;
                n_snap.right   = n_right;
                n_snap_valid   = 1'b1;
                n_phase        = PH_WAIT;
            end
        end
    end

    // State and snapshot registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_col_acc    <= '0;
            r_run_acc    <= '0;
            r_left       <= '0;
            r_right      <= '0;
            r_origin     <= '0;
            r_snap_valid <= 1'b0;
            r_snap       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_col_acc    <= n_col_acc;
            r_run_acc    <= n_run_acc;
            r_left       <= n_left;
            r_right      <= n_right;
            r_origin     <= n_origin;
            r_snap_valid <= n_snap_valid;
            r_snap       <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

>>> hdl/ccut_judge.sv
// ----------------------------------------------------------------------------
// ccut_judge
// Grades a finished run, keeps the cut counter and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccut_judge (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ccut_pkg::t_cfg  i_cfg,
    input  wire logic            i_snap_valid,
    output logic                 o_snap_ready,
    input  wire ccut_pkg::t_snap i_snap,
    output logic [1:0]           o_cut_cnt,
    output logic [1:0]           o_cut_next,
    // result channel
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [1:0]           o_status,
    output logic [9:0]           o_left_edge,
    output logic [9:0]           o_right_edge
);
    import ccut_pkg::*;

    logic                r_out_valid;
    logic [1:0]          r_status,   n_status;
    logic [9:0]          r_left;
    logic [9:0]          r_right;
    logic [1:0]          r_cut_cnt,  n_cut_cnt;

    logic                load;
    logic signed [10:0]  width;
    logic signed [27:0]  need;
    logic signed [27:0]  have;
    logic                sparse;
    logic                wide;

    assign o_snap_ready = !r_out_valid || i_out_ready;
    assign load         = i_snap_valid && o_snap_ready;

    // Run density against width times threshold, signed
    assign width  = $signed({1'b0, i_snap.right} - {1'b0, i_snap.left});
    assign need   = 28'(width) * $signed({12'd0, i_cfg.threshold});
    assign have   = $signed({3'b000, i_snap.run_acc});
    assign sparse = have < need;

    // Width limit, waived on the third cut
    assign wide = (width > $signed({3'b000, div7(i_cfg.image_cols)}))
                  && (r_cut_cnt != 2'd2);

    always_comb begin
        n_cut_cnt = r_cut_cnt;
        if (sparse) begin
            n_status = ST_SPARSE;
        end else if (wide) begin
            n_status = ST_WIDE;
        end else begin
            n_status = ST_OK;
            if (r_cut_cnt != 2'd3) begin
                n_cut_cnt = r_cut_cnt + 2'd1;
            end
        end
    end

    // Result register and cut counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cut_cnt   <= '0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_cut_cnt   <= n_cut_cnt;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= n_status;
            r_left   <= i_snap.left;
            r_right  <= i_snap.right;
        end
    end

    // The scanner sees the count after the run being graded in this cycle
    assign o_cut_next   = load ? n_cut_cnt : r_cut_cnt;
    assign o_cut_cnt    = r_cut_cnt;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_left_edge  = r_left;
    assign o_right_edge = r_right;

endmodule

`default_nettype wire

>>> hdl/column_projection_char_cutter_top.sv
// A result passes the scanner's snapshot register, then the judge's result register.
// Throughput: one pixel per cycle; the pixel channel only stalls when an
//   image result is held up behind a result that has not yet been taken.
// Reset: synchronous, active low; clears the scan state, the cut counter and
//   the registers (image_cols to its cap, row_last to the last row).
// ----------------------------------------------------------------------------
// column_projection_char_cutter_top
// Vertical projection character cutter: column sums, run search, grading.
// ----------------------------------------------------------------------------
`default_nettype none

`include "column_projection_char_cutter_top_defines.svh"

module column_projection_char_cutter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // pixel channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_pixel,
    input  wire logic [7:0]  i_row,
    input  wire logic [8:0]  i_column,
    input  wire logic        i_column_end,
    input  wire logic        i_image_end,
    input  wire logic [8:0]  i_start_column,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [9:0]       o_left_edge,
    output logic [9:0]       o_right_edge
);
    import ccut_pkg::*;

    t_cfg        r_cfg;
    logic        snap_valid;
    logic        snap_ready;
    t_snap       snap;
    logic [1:0]  cut_cnt;
    logic [1:0]  cut_next;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_cols <= COLS_CAP;
            r_cfg.row_first  <= '0;
            r_cfg.row_last   <= ROW_LAST_RESET;
            r_cfg.threshold  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_COLS: r_cfg.image_cols <= (i_cfg_data[9:0] > COLS_CAP) ?
                                                    COLS_CAP : i_cfg_data[9:0];
                CFG_ROW_FIRST:  r_cfg.row_first  <= i_cfg_data[7:0];
                CFG_ROW_LAST:   r_cfg.row_last   <= i_cfg_data[7:0];
                CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ccut_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cut_cnt      (cut_next),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_column_end   (i_column_end),
        .i_image_end    (i_image_end),
        .i_start_column (i_start_column),
        .o_snap_valid   (snap_valid),
        .i_snap_ready   (snap_ready),
        .o_snap         (snap)
    );

    ccut_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_cut_cnt    (cut_cnt),
        .o_cut_next   (cut_next),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_left_edge  (o_left_edge),
        .o_right_edge (o_right_edge)
    );

    // Checks
    `CCUT_ASSERT(a_status_code, i_clk, i_rst_n,
        !o_out_valid || o_status == ST_OK || o_status == ST_SPARSE || o_status == ST_WIDE)
    `CCUT_ASSERT(a_right_in_image, i_clk, i_rst_n,
        !o_out_valid || o_right_edge <= COLS_CAP)
    `CCUT_ASSERT(a_stall_cause, i_clk, i_rst_n,
        o_in_ready || (snap_valid && o_out_valid && !i_out_ready))
    `CCUT_ASSERT_NEXT(a_cut_ok_only, i_clk, i_rst_n,
        cut_cnt != 2'd3, (cut_cnt == $past(cut_cnt)) || (o_status == ST_OK))

endmodule

`default_nettype wire

>>> tb/column_projection_char_cutter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_projection_char_cutter_top_test
// Streams column-major plate images through the cutter under changing window,
// width and threshold settings, and checks every cut result against a
// cycle-free model of the column sums, run search and grading, or a typed result.
// ----------------------------------------------------------------------------

module column_projection_char_cutter_top_test;
    import ccut_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int LIMIT_NS   = 8_000_000;
    localparam int PHASES     = 14;
    localparam int PHASE_PIX  = 60;

    // idling modes
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_SINK = 2;
    localparam int IDLE_BOTH = 3;

    typedef enum logic [1:0] {
        SCAN_WAIT, SCAN_SEARCH, SCAN_RUN, SCAN_DONE
    } t_scan;

    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] row;
        logic [8:0] column;
        logic       column_end;
        logic       image_end;
        logic [8:0] start_column;
    } t_pixel;

    typedef struct packed {
        t_status    status;
        logic [9:0] left_edge;
        logic [9:0] right_edge;
    } t_cut;

    // one line of the directed plan: a register write or a pixel
    typedef struct {
        bit          is_write;
        logic [1:0]  reg_index;
        logic [15:0] reg_data;
        t_pixel      px;
        bit          typed;
        t_cut        typed_cut;
    } t_step;

    // DUT ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_pixel;
    logic [7:0]  i_row;
    logic [8:0]  i_column;
    logic        i_column_end;
    logic        i_image_end;
    logic [8:0]  i_start_column;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [9:0]  o_left_edge;
    logic [9:0]  o_right_edge;

    column_projection_char_cutter_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel        (i_pixel),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_column_end   (i_column_end),
        .i_image_end    (i_image_end),
        .i_start_column (i_start_column),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_left_edge    (o_left_edge),
        .o_right_edge   (o_right_edge)
    );

    // Model state: registers and scan
    logic [9:0]  cfg_cols;
    logic [7:0]  cfg_row_first;
    logic [7:0]  cfg_row_last;
    logic [15:0] cfg_threshold;
    logic [15:0] col_sum;
    logic [24:0] run_sum;
    t_scan       scan;
    logic [9:0]  run_l;
    logic [9:0]  run_r;
    logic [8:0]  origin;
    logic [1:0]  cut_count;

    t_cut pending_cuts[$];
    int   mismatches = 0;
    int   sent = 0;
    int   idle_mode = IDLE_NONE;
    int   hold_request = 0;
    bit   use_typed = 0;
    t_cut typed_cut = '0;

    function automatic void clear_model();
        cfg_cols      = COLS_CAP;
        cfg_row_first = 8'd0;
        cfg_row_last  = ROW_LAST_RESET;
        cfg_threshold = 16'd0;
        col_sum       = 16'd0;
        run_sum       = 25'd0;
        scan          = SCAN_WAIT;
        run_l         = 10'd0;
        run_r         = 10'd0;
        origin        = 9'd0;
        cut_count     = 2'd0;
    endfunction

    function automatic void apply_write(input logic [1:0] idx, input logic [15:0] d);
        case (idx)
            CFG_IMAGE_COLS: cfg_cols = (d[9:0] > COLS_CAP) ? COLS_CAP : d[9:0];
            CFG_ROW_FIRST:  cfg_row_first = d[7:0];
            CFG_ROW_LAST:   cfg_row_last = d[7:0];
            CFG_THRESHOLD:  cfg_threshold = d;
            default: ;
        endcase
    endfunction

    // run must reach this width before a low column may end it
    function automatic int min_run_width();
        case (cut_count)
            2'd0:    return int'(cfg_cols) / 10;
            2'd2:    return int'(cfg_cols) / 8;
            default: return int'(cfg_cols) / 12;
        endcase
    endfunction

    function automatic void close_column(input logic [8:0] col, input logic [15:0] sum);
        int total;
        int w;
        // columns past the image edge are dropped
        if (col < cfg_cols) begin
            if (scan == SCAN_SEARCH) begin
                if (col >= origin && sum > cfg_threshold) begin
                    run_l   = 10'(col);
                    run_r   = 10'(col);
                    run_sum = 25'(sum);
                    scan    = SCAN_RUN;
                end
            end else if (scan == SCAN_RUN) begin
                total   = int'(run_sum) + int'(sum);
                run_sum = (total > 33554431) ? '1 : 25'(total);
                if (sum < cfg_threshold) begin
                    run_r = 10'(col);
                    w     = int'(run_r) - int'(run_l);
                    if (w >= min_run_width())
                        scan = SCAN_DONE;
                end
            end
        end
    endfunction

    // Advance the model by one pixel; returns 1 when a cut result is due
    function automatic bit project_pixel(input t_pixel px, output t_cut cut);
        int     sum;
        int     w;
        longint bar;
        if (scan == SCAN_WAIT) begin
            origin  = px.start_column;
            run_l   = 10'(px.start_column);
            run_r   = 10'd0;
            run_sum = 25'd0;
            scan    = SCAN_SEARCH;
        end
        if (px.row >= cfg_row_first && px.row <= cfg_row_last) begin
            sum     = int'(col_sum) + int'(px.pixel);
            col_sum = (sum > 65535) ? 16'hFFFF : 16'(sum);
        end
        // last pixel of the image also closes its column
        if (px.column_end || px.image_end) begin
            close_column(px.column, col_sum);
            col_sum = 16'd0;
        end
        cut = '0;
        if (px.image_end) begin
            if (scan != SCAN_DONE)
                run_r = cfg_cols;
            w   = int'(run_r) - int'(run_l);
            bar = longint'(w) * longint'(cfg_threshold);
            if (longint'(run_sum) < bar) begin
                cut.status = ST_SPARSE;
            end else if (w > int'(cfg_cols) / 7 && cut_count != 2'd2) begin
                cut.status = ST_WIDE;
            end else begin
                cut.status = ST_OK;
                if (cut_count != 2'd3)
                    cut_count = cut_count + 2'd1;
            end
            cut.left_edge  = run_l;
            cut.right_edge = run_r;
            scan = SCAN_WAIT;
        end
        return px.image_end;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Result checker and model update, all at the rising edge
    always @(posedge i_clk) begin : watch
        t_cut want;
        t_cut pred;
        t_pixel px;
        if (!i_rst_n) begin
            clear_model();
            pending_cuts.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_cuts.size() == 0) begin
                    $error("cut result with none pending: status %0d left %0d right %0d",
                           o_status, o_left_edge, o_right_edge);
                    mismatches++;
                end else begin
                    want = pending_cuts.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_left_edge !== want.left_edge) begin
                        $error("left_edge: expected %0d, got %0d", want.left_edge,
                               o_left_edge);
                        mismatches++;
                    end
                    if (o_right_edge !== want.right_edge) begin
                        $error("right_edge: expected %0d, got %0d", want.right_edge,
                               o_right_edge);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                px = {i_pixel, i_row, i_column, i_column_end, i_image_end, i_start_column};
                if (project_pixel(px, pred))
                    pending_cuts.insert(pending_cuts.size(), use_typed ? typed_cut : pred);
            end
        end
    end

    function automatic bit sender_rests();
        if (idle_mode == IDLE_SEND)
            return $urandom_range(0, 99) < 83;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 18;
        return 1'b0;
    endfunction

    function automatic bit sink_stalls();
        if (idle_mode == IDLE_SINK)
            return $urandom_range(0, 99) < 83;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 18;
        return 1'b0;
    endfunction

    // Result side: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !sink_stalls();
            end
        end
    end

    // Present one pixel and wait for its transfer; returns at a falling edge
    // with valid still up, so the caller either sends again or lowers it.
    task automatic send_pixel(input t_pixel px, input bit typed, input t_cut want);
        int gap;
        gap = 0;
        while (gap < 40 && sender_rests()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            gap++;
        end
        i_in_valid     <= 1'b1;
        i_pixel        <= px.pixel;
        i_row          <= px.row;
        i_column       <= px.column;
        i_column_end   <= px.column_end;
        i_image_end    <= px.image_end;
        i_start_column <= px.start_column;
        use_typed = typed;
        typed_cut = want;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        sent++;
    endtask

    // Stop sending and wait until every pending cut has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_cuts.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [15:0] cols, input logic [7:0] first,
                             input logic [7:0] last, input logic [15:0] thr);
        settle();
        write_reg(CFG_IMAGE_COLS, cols);
        write_reg(CFG_ROW_FIRST, {8'd0, first});
        write_reg(CFG_ROW_LAST, {8'd0, last});
        write_reg(CFG_THRESHOLD, thr);
    endtask

    // Column-major image with alternating ink and gap runs; a broken image
    // loses some column ends, including the one on its last pixel.
    task automatic send_image(input int ncols, input int nrows, input logic [8:0] start,
                              input bit broken);
        int         c;
        int         r;
        bit         ink;
        logic [7:0] base;
        t_pixel     px;
        ink  = 1'b0;
        base = 8'($urandom);
        for (c = 0; c < ncols; c++) begin
            if ($urandom_range(0, 99) < 30)
                ink = !ink;
            for (r = 0; r < nrows; r++) begin
                if (ink)
                    px.pixel = ($urandom_range(0, 9) < 8) ? 8'd255 : 8'd0;
                else
                    px.pixel = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'd0;
                if ($urandom_range(0, 19) == 0)
                    px.pixel = 8'($urandom);
                px.row          = 8'(base + r);
                px.column       = 9'(c);
                px.column_end   = (r == nrows - 1);
                px.image_end    = (c == ncols - 1 && r == nrows - 1);
                px.start_column = (c == 0 && r == 0) ? start : 9'($urandom);
                if (broken && px.column_end && ($urandom_range(0, 3) == 0 || px.image_end))
                    px.column_end = 1'b0;
                send_pixel(px, 1'b0, '0);
            end
        end
    endtask

    task automatic send_noise(input int n);
        t_pixel px;
        repeat (n) begin
            px.pixel        = 8'($urandom);
            px.row          = 8'($urandom);
            px.column       = 9'($urandom);
            px.column_end   = 1'($urandom);
            px.image_end    = ($urandom_range(0, 7) == 0);
            px.start_column = 9'($urandom);
            send_pixel(px, 1'b0, '0);
        end
    endtask

    function automatic t_step pixel_row(input logic [7:0] p, input logic [7:0] r,
                                        input logic [8:0] c, input logic ce,
                                        input logic ie, input logic [8:0] s,
                                        input bit typed, input t_cut want);
        t_step st;
        st.is_write  = 1'b0;
        st.reg_index = CFG_IMAGE_COLS;
        st.reg_data  = 16'd0;
        st.px        = {p, r, c, ce, ie, s};
        st.typed     = typed;
        st.typed_cut = want;
        return st;
    endfunction

    function automatic t_step write_row(input logic [1:0] idx, input logic [15:0] data);
        t_step st;
        st.is_write  = 1'b1;
        st.reg_index = idx;
        st.reg_data  = data;
        st.px        = '0;
        st.typed     = 1'b0;
        st.typed_cut = '0;
        return st;
    endfunction

    // Stimulus
    initial begin : stimulus
        t_step       plan[$];
        int          i;
        int          phase;
        int          cols;
        int          rows;
        int          first;
        int          last;
        int          thr;
        int          ncols;
        int          phase_start;
        int          c;
        int          r;
        logic [8:0]  start;
        t_pixel      px;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_IMAGE_COLS;
        i_cfg_data     = 16'd0;
        i_in_valid     = 1'b0;
        i_pixel        = 8'd0;
        i_row          = 8'd0;
        i_column       = 9'd0;
        i_column_end   = 1'b0;
        i_image_end    = 1'b0;
        i_start_column = 9'd0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed plan, starting from reset settings (512 columns, full window)
        plan.insert(plan.size(), pixel_row(8'd255, 8'd0, 9'd0, 1'b1, 1'b1, 9'd0, 1'b1,
                                           {ST_WIDE, 10'd0, 10'd512}));
        plan.insert(plan.size(), pixel_row(8'd0, 8'd255, 9'd511, 1'b1, 1'b1, 9'd511, 1'b1,
                                           {ST_OK, 10'd511, 10'd512}));
        plan.insert(plan.size(), write_row(CFG_THRESHOLD, 16'd65280));
        plan.insert(plan.size(), pixel_row(8'd255, 8'd0, 9'd0, 1'b1, 1'b1, 9'd0, 1'b1,
                                           {ST_SPARSE, 10'd0, 10'd512}));
        // width above the cap saturates
        plan.insert(plan.size(), write_row(CFG_IMAGE_COLS, 16'd1023));
        plan.insert(plan.size(), write_row(CFG_THRESHOLD, 16'd0));
        // empty row window: every column sums to zero
        plan.insert(plan.size(), write_row(CFG_ROW_FIRST, 16'd255));
        plan.insert(plan.size(), write_row(CFG_ROW_LAST, 16'd0));
        plan.insert(plan.size(), pixel_row(8'd255, 8'd255, 9'd0, 1'b1, 1'b0, 9'd0, 1'b0,
                                           '0));
        // image end without column end
        plan.insert(plan.size(), pixel_row(8'd255, 8'd0, 9'd1, 1'b0, 1'b1, 9'd0, 1'b1,
                                           {ST_WIDE, 10'd0, 10'd512}));
        plan.insert(plan.size(), write_row(CFG_ROW_FIRST, 16'd0));
        plan.insert(plan.size(), write_row(CFG_ROW_LAST, 16'd255));
        plan.insert(plan.size(), write_row(CFG_IMAGE_COLS, 16'd20));
        plan.insert(plan.size(), write_row(CFG_THRESHOLD, 16'd100));
        // run opens at column 4, a column out of order gives a negative width,
        // a column past the edge is dropped, then the run closes at column 6
        plan.insert(plan.size(), pixel_row(8'd255, 8'd3, 9'd4, 1'b1, 1'b0, 9'd2, 1'b0, '0));
        plan.insert(plan.size(), pixel_row(8'd0, 8'd0, 9'd2, 1'b1, 1'b0, 9'd0, 1'b0, '0));
        plan.insert(plan.size(), pixel_row(8'd0, 8'd0, 9'd25, 1'b1, 1'b0, 9'd0, 1'b0, '0));
        plan.insert(plan.size(), pixel_row(8'd0, 8'd0, 9'd6, 1'b1, 1'b1, 9'd0, 1'b0, '0));
        // search start beyond the image edge
        plan.insert(plan.size(), pixel_row(8'd255, 8'd0, 9'd3, 1'b1, 1'b1, 9'd300, 1'b0,
                                           '0));

        for (i = 0; i < plan.size(); i++) begin
            if (plan[i].is_write) begin
                settle();
                write_reg(plan[i].reg_index, plan[i].reg_data);
            end else begin
                send_pixel(plan[i].px, plan[i].typed, plan[i].typed_cut);
            end
        end

        // Random phases, each with its own settings and idling
        for (phase = 0; phase < PHASES; phase++) begin
            rows = $urandom_range(1, 3);
            cols = $urandom_range(4, 24);
            case (phase % 3)
                0: begin
                    first = 0;
                    last  = 255;
                end
                1: begin
                    first = $urandom_range(0, 127);
                    last  = $urandom_range(128, 255);
                end
                default: begin
                    first = $urandom_range(0, 255);
                    last  = $urandom_range(0, 255);
                end
            endcase
            thr = $urandom_range(0, rows * 255);
            if (phase == 3)
                cols = 1;
            if (phase == 5) begin
                first = 255;
                last  = 255;
                thr   = 0;
            end
            if (phase == 7) begin
                cols = 512;
                rows = 1;
            end
            if (phase == 9)
                thr = 16'hFFFF;
            if (phase == 11)
                thr = 65280;
            configure(16'(cols), 8'(first), 8'(last), 16'(thr));
            idle_mode = phase % 4;

            // results pile up behind a long hold-off while pixels keep coming
            if (phase == 4) begin
                hold_request = 300;
                repeat (30) send_image(1, 1, 9'($urandom_range(0, 3)), 1'b0);
                settle();
            end

            phase_start = sent;
            while (sent - phase_start < PHASE_PIX) begin
                if ($urandom_range(0, 99) < 85) begin
                    ncols = cols;
                    if (cols < 512 && $urandom_range(0, 9) == 0)
                        ncols = cols + $urandom_range(1, 3);
                    if ($urandom_range(0, 99) < 80)
                        start = 9'($urandom_range(0, ncols / 3));
                    else
                        start = 9'($urandom);
                    send_image(ncols, rows, start, $urandom_range(0, 9) == 0);
                end else begin
                    send_noise($urandom_range(1, 6));
                end
            end
        end

        // Saturate the column sum: overfull columns of repeated rows
        configure(16'(COLS_CAP), 8'd0, 8'd255, 16'd0);
        idle_mode = IDLE_NONE;
        for (c = 0; c <= 1; c++) begin
            for (r = 0; r < 258; r++) begin
                px.pixel        = 8'd255;
                px.row          = 8'(r);
                px.column       = 9'(c);
                px.column_end   = (r == 257);
                px.image_end    = (c == 1 && r == 257);
                px.start_column = 9'd0;
                send_pixel(px, 1'b0, '0);
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && pending_cuts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ccut_pkg.sv
hdl/ccut_scan.sv
hdl/ccut_judge.sv
hdl/column_projection_char_cutter_top.sv
tb/column_projection_char_cutter_top_test.sv
